/* src/sct_pkg.sv */
package sct_pkg;

	localparam int FUNC_W   = 2;
	localparam int IN_KEY_W = 16;
	localparam int COUNT_W  = 16;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 6;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADINDEX = 3'd4;

	// update broadcast to every cell in the apply cycle
	typedef struct packed {
		logic ins_new;
		logic ins_inc;
		logic dec;
		logic del;
	} ctl_t;

	// per-cell compare results
	typedef struct packed {
		logic eq;
		logic gt;
		logic fhit;
		logic at_slot;
		logic ins_here;
	} flag_t;

endpackage

/* src/sct_cell.sv */
module sct_cell import sct_pkg::*; #(
	parameter int INDEX    = 0,
	parameter int KEY_BITS = 16
) (
	input  logic                clk,
	input  ctl_t                ctl,
	input  logic [KEY_BITS-1:0] key_in,
	input  logic [COUNT_W-1:0]  min_count,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                occ,
	input  logic                left_occ,
	input  logic                left_gt,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [COUNT_W-1:0]  left_count,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [COUNT_W-1:0]  right_count,
	output flag_t               flag,
	output logic [KEY_BITS-1:0] key_out,
	output logic [COUNT_W-1:0]  count_out
);

	logic [KEY_BITS-1:0] key_q;
	logic [COUNT_W-1:0]  count_q;
	logic                at_or_after;

	assign at_or_after = 32'(INDEX) >= 32'(slot);

	always_comb begin
		flag.eq       = occ && (key_q == key_in);
		flag.gt       = occ && (key_q > key_in);
		flag.fhit     = flag.eq && (count_q >= min_count);
		flag.at_slot  = occ && (32'(slot) == 32'(INDEX));
		// first place whose key is larger, or the first free place
		flag.ins_here = (flag.gt || !occ) && left_occ && !left_gt;
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_new) begin
			if (left_gt) begin
				key_q   <= left_key;
				count_q <= left_count;
			end else if (flag.ins_here) begin
				key_q   <= key_in;
				count_q <= COUNT_ONE;
			end
		end else if (ctl.ins_inc && flag.eq && count_q != COUNT_MAX) begin
			count_q <= count_q + COUNT_ONE;
		end else if (ctl.dec && flag.at_slot) begin
			count_q <= count_q - COUNT_ONE;
		end else if (ctl.del && at_or_after) begin
			// close the gap: pull from the right neighbor
			key_q   <= right_key;
			count_q <= right_count;
		end
	end

	assign key_out   = key_q;
	assign count_out = count_q;

endmodule

/* src/sorted_counted_table.sv */
// Sorted table of distinct keys with occurrence counts, held in a row of cells.
// Command channel: an operation (func, key, min_count, slot) transfers at the
// rising edge where start is high and busy is low. busy is high for one cycle
// after each transfer while every cell compares its key against the command
// and shifts or updates in place.
// Result channel: done pulses for one cycle with status, where_index,
// hit_count and occupancy; the result is taken in that cycle, the receiver
// cannot stall it.
// The command registers load at the command edge together with busy; done is
// registered from busy, and the result registers load while busy is high.
// A new command cannot transfer while busy is high: in that cycle every cell
// runs the compare against the command, and the one-hot reduction of their
// flags feeds the shift of the cell registers.
// A new command may transfer at the edge that ends the cycle the previous
// result is shown.
// Reset clears the fill level, busy and done; cell contents are left as they
// are and only entries below the fill level are ever read, so no clearing
// pass is needed.
module sorted_counted_table import sct_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [IN_KEY_W-1:0] key,
	input  logic [COUNT_W-1:0]  min_count,
	input  logic [SLOT_W-1:0]   slot,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   where_index,
	output logic [COUNT_W-1:0]  hit_count,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int SW     = (FILL_W > SLOT_W) ? FILL_W : SLOT_W;

	logic                busy_q;
	logic                done_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [COUNT_W-1:0]  min_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   where_q;
	logic [COUNT_W-1:0]  hit_q;
	logic [OCC_W-1:0]    occ_q;

	logic [KEY_BITS-1:0] key_masked;
	flag_t               flags [CAPACITY];
	logic [KEY_BITS-1:0] keys [CAPACITY];
	logic [COUNT_W-1:0]  counts [CAPACITY];
	logic [CAPACITY-1:0] occ_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] ins_vec;
	ctl_t                ctl;

	logic                accept;
	logic                full;
	logic                empty;
	logic                bad_slot;
	logic                found;
	logic                fhit_any;
	logic [IDX_W-1:0]    eq_idx;
	logic [IDX_W-1:0]    ins_idx;
	logic [IDX_W-1:0]    fhit_idx;
	logic [COUNT_W-1:0]  eq_cnt;
	logic [COUNT_W-1:0]  slot_cnt;
	logic [COUNT_W-1:0]  fhit_cnt;
	logic [FILL_W-1:0]   fill_next;
	logic [STATUS_W-1:0] status_d;
	logic [SLOT_W-1:0]   where_d;
	logic [COUNT_W-1:0]  hit_d;

	assign accept     = start && !busy_q;
	assign key_masked = KEY_BITS'(key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			fill_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				fill_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key_masked;
			min_q  <= min_count;
			slot_q <= slot;
		end
		if (busy_q) begin
			status_q <= status_d;
			where_q  <= where_d;
			hit_q    <= hit_d;
			occ_q    <= OCC_W'(fill_next);
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic                l_occ;
			logic                l_gt;
			logic [KEY_BITS-1:0] l_key;
			logic [COUNT_W-1:0]  l_cnt;
			logic [KEY_BITS-1:0] r_key;
			logic [COUNT_W-1:0]  r_cnt;

			assign occ_vec[g] = 32'(fill_q) > 32'(g);
			assign eq_vec[g]  = flags[g].eq;
			assign ins_vec[g] = flags[g].ins_here;

			if (g == 0) begin : g_first
				assign l_occ = 1'b1;
				assign l_gt  = 1'b0;
				assign l_key = keys[g];
				assign l_cnt = counts[g];
			end else begin : g_mid
				assign l_occ = occ_vec[g-1];
				assign l_gt  = flags[g-1].gt;
				assign l_key = keys[g-1];
				assign l_cnt = counts[g-1];
			end

			if (g == CAPACITY - 1) begin : g_last
				assign r_key = keys[g];
				assign r_cnt = counts[g];
			end else begin : g_inner
				assign r_key = keys[g+1];
				assign r_cnt = counts[g+1];
			end

			sct_cell #(
				.INDEX    (g),
				.KEY_BITS (KEY_BITS)
			) u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.key_in      (key_q),
				.min_count   (min_q),
				.slot        (slot_q),
				.occ         (occ_vec[g]),
				.left_occ    (l_occ),
				.left_gt     (l_gt),
				.left_key    (l_key),
				.left_count  (l_cnt),
				.right_key   (r_key),
				.right_count (r_cnt),
				.flag        (flags[g]),
				.key_out     (keys[g]),
				.count_out   (counts[g])
			);
		end
	endgenerate

	// one-hot reductions of the cell flags
	always_comb begin
		found    = 1'b0;
		fhit_any = 1'b0;
		eq_idx   = '0;
		ins_idx  = '0;
		fhit_idx = '0;
		eq_cnt   = '0;
		slot_cnt = '0;
		fhit_cnt = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			found    = found | flags[j].eq;
			fhit_any = fhit_any | flags[j].fhit;
			eq_idx   = eq_idx | (flags[j].eq ? IDX_W'(j) : '0);
			ins_idx  = ins_idx | (flags[j].ins_here ? IDX_W'(j) : '0);
			fhit_idx = fhit_idx | (flags[j].fhit ? IDX_W'(j) : '0);
			eq_cnt   = eq_cnt | (flags[j].eq ? counts[j] : '0);
			slot_cnt = slot_cnt | (flags[j].at_slot ? counts[j] : '0);
			fhit_cnt = fhit_cnt | (flags[j].fhit ? counts[j] : '0);
		end
	end

	assign full     = 32'(fill_q) >= 32'(CAPACITY);
	assign empty    = fill_q == '0;
	assign bad_slot = SW'(slot_q) >= SW'(fill_q);

	always_comb begin
		ctl       = '0;
		fill_next = fill_q;
		status_d  = ST_OK;
		where_d   = '0;
		hit_d     = '0;
		case (func_q)
			FN_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (found) begin
					ctl.ins_inc = busy_q;
					where_d     = SLOT_W'(eq_idx);
					hit_d       = (eq_cnt == COUNT_MAX) ? eq_cnt : eq_cnt + COUNT_ONE;
				end else begin
					ctl.ins_new = busy_q;
					fill_next   = fill_q + FILL_W'(1);
					where_d     = SLOT_W'(ins_idx);
					hit_d       = COUNT_ONE;
				end
			end
			FN_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (bad_slot) begin
					status_d = ST_BADINDEX;
				end else if (slot_cnt > COUNT_ONE) begin
					ctl.dec = busy_q;
					where_d = slot_q;
					hit_d   = slot_cnt - COUNT_ONE;
				end else begin
					// drop the entry
					ctl.del   = busy_q;
					fill_next = fill_q - FILL_W'(1);
					where_d   = slot_q;
				end
			end
			FN_FIND: begin
				if (fhit_any) begin
					where_d = SLOT_W'(fhit_idx);
					hit_d   = fhit_cnt;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign where_index = where_q;
	assign hit_count   = hit_q;
	assign occupancy   = occ_q;

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a preceding apply cycle");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(CAPACITY))
		else $error("fill level above capacity");

	a_keys_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ($onehot0(eq_vec) && $onehot0(ins_vec)))
		else $error("table order broken: more than one matching or insert cell");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (fill_q == $past(fill_q) || fill_q == $past(fill_q) + FILL_W'(1)
			|| fill_q == $past(fill_q) - FILL_W'(1)))
		else $error("fill level moved by more than one");

endmodule
